>>> sv/hwt_pkg.sv
package hwt_pkg;

  // Input item kinds
  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindSep  = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  // Configuration register indexes
  localparam logic CfgMaxTokens = 1'b0;
  localparam logic CfgPadMode   = 1'b1;

  // Fixed figures of the tokenizer
  localparam int unsigned MaxTokensLimit = 64;
  localparam int unsigned CountW         = 7;
  localparam int unsigned IdW            = 15;
  localparam int unsigned CfgW           = 7;
  localparam logic [31:0] FnvBasis       = 32'd2166136261;
  localparam logic [31:0] FnvPrime       = 32'd16777619;
  localparam logic [31:0] IdModulus      = 32'd30000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] token_id;
    logic           attend;
    logic           last_token;
  } out_item_t;

endpackage

>>> sv/hashed_word_tokenizer_core.sv
// Hashed word tokenizer: lowercases ASCII text bytes, splits words on whitespace
// (bytes 9-13, 32) or a separator item, hashes each word with 32-bit FNV-1a and
// emits hash mod 30000 as token id, up to max_tokens tokens. Text bytes and
// separators are taken at one item per cycle while the pipeline has room. An
// end-of-text item holds the input until the further results it causes (a pending
// held token, the final token, and in pad mode the padding up to max_tokens, at
// most 64 results in all) have entered the pipeline, which takes one per cycle
// while it has room. Every result passes a three-register modulo pipeline
// (reciprocal multiply, then multiply-subtract with one correction), held in
// the a, b and output registers in turn. The output register decouples the
// channels; a stalled consumer only blocks input once the pipeline fills.
module hashed_word_tokenizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hwt_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hwt_pkg::out_item_t out_item_o
);
  import hwt_pkg::*;

  localparam int unsigned RecipShift = 44;
  localparam logic [29:0] ModRecip   = 30'((64'd1 << RecipShift) / 64'd30000);

  typedef struct packed {
    logic [31:0] hash;
    logic        attend;
    logic        last;
  } entry_t;

  // Configuration registers
  logic [CountW-1:0] max_tokens_q;
  logic              pad_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= CountW'(MaxTokensLimit);
      pad_mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxTokens: max_tokens_q <= cfg_wdata_i;
        CfgPadMode:   pad_mode_q   <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  // Tokenizer state
  logic [31:0]       word_hash_q, word_hash_d;
  logic              inside_q, inside_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       held_q, held_d;
  logic              held_valid_q, held_valid_d;
  logic              seq_final_q, seq_final_d;
  logic [CountW-1:0] pad_left_q, pad_left_d;

  // Pipeline stages
  logic        a_valid_q, b_valid_q, out_valid_q;
  entry_t      a_q, b_q;
  logic [17:0] b_quot_q;
  out_item_t   out_q;
  logic        a_en, b_en, out_en;

  assign out_en = !out_valid_q || out_ready_i;
  assign b_en   = !b_valid_q || out_en;
  assign a_en   = !a_valid_q || b_en;

  logic              busy;
  logic              in_fire;
  logic [CountW-1:0] lim;
  logic              word_take;
  logic              is_space;
  logic [7:0]        low_byte;
  logic [31:0]       hash_base;
  logic [31:0]       new_held;
  logic [CountW-1:0] made;
  logic [CountW-1:0] pads;
  logic              push;
  entry_t            push_entry;

  assign busy       = seq_final_q || (pad_left_q != '0);
  assign in_ready_o = a_en && !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // Clamp the token limit to 1..MaxTokensLimit
  always_comb begin
    if (max_tokens_q == '0) begin
      lim = CountW'(1);
    end else if (max_tokens_q > CountW'(MaxTokensLimit)) begin
      lim = CountW'(MaxTokensLimit);
    end else begin
      lim = max_tokens_q;
    end
  end

  assign word_take = inside_q && (count_q < lim);
  assign is_space  = (in_item_i.text_byte == 8'd32) ||
                     ((in_item_i.text_byte >= 8'd9) && (in_item_i.text_byte <= 8'd13));
  assign low_byte  = ((in_item_i.text_byte >= 8'd65) && (in_item_i.text_byte <= 8'd90)) ?
                     (in_item_i.text_byte | 8'h20) : in_item_i.text_byte;
  assign hash_base = inside_q ? word_hash_q : FnvBasis;

  // Final token and padding count for an end-of-text item
  assign new_held = word_take ? word_hash_q : held_q;
  always_comb begin
    made = count_q + CountW'(word_take);
    if (made == '0) begin
      made = CountW'(1);
    end
    pads = (pad_mode_q && (made < lim)) ? (lim - made) : '0;
  end

  // Word, token and end-of-text sequencing
  always_comb begin
    word_hash_d  = word_hash_q;
    inside_d     = inside_q;
    count_d      = count_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    seq_final_d  = seq_final_q;
    pad_left_d   = pad_left_q;
    push         = 1'b0;
    push_entry   = '{hash: held_q, attend: 1'b1, last: 1'b0};

    if (busy) begin
      if (a_en) begin
        push = 1'b1;
        if (seq_final_q) begin
          // emit the final token of the text
          push_entry  = '{hash: held_q, attend: 1'b1, last: (pad_left_q == '0)};
          held_d      = '0;
          seq_final_d = 1'b0;
        end else begin
          // emit one padding position
          push_entry = '{hash: '0, attend: 1'b0, last: (pad_left_q == CountW'(1))};
          pad_left_d = pad_left_q - CountW'(1);
        end
      end
    end else if (in_fire) begin
      if ((in_item_i.kind == KindSep) || ((in_item_i.kind == KindByte) && is_space)) begin
        // close the word; release the previously held token
        if (word_take) begin
          push         = held_valid_q;
          held_d       = word_hash_q;
          held_valid_d = 1'b1;
          count_d      = count_q + CountW'(1);
        end
        inside_d    = 1'b0;
        word_hash_d = FnvBasis;
      end else if (in_item_i.kind == KindByte) begin
        // fold the byte into the word hash
        word_hash_d = 32'((hash_base ^ {24'd0, low_byte}) * FnvPrime);
        inside_d    = 1'b1;
      end else if (in_item_i.kind == KindEnd) begin
        push       = 1'b1;
        pad_left_d = pads;
        if (word_take && held_valid_q) begin
          // old held token first, final token after it
          seq_final_d = 1'b1;
          held_d      = new_held;
        end else begin
          push_entry = '{hash: new_held, attend: 1'b1, last: (pads == '0)};
          held_d     = '0;
        end
        held_valid_d = 1'b0;
        count_d      = '0;
        inside_d     = 1'b0;
        word_hash_d  = FnvBasis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_hash_q  <= FnvBasis;
      inside_q     <= 1'b0;
      count_q      <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      seq_final_q  <= 1'b0;
      pad_left_q   <= '0;
    end else begin
      word_hash_q  <= word_hash_d;
      inside_q     <= inside_d;
      count_q      <= count_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      seq_final_q  <= seq_final_d;
      pad_left_q   <= pad_left_d;
    end
  end

  // Modulo pipeline: quotient estimate, then remainder with one correction
  logic [17:0] quot_est;
  logic [31:0] rem_raw;
  logic [31:0] rem_fix;

  assign quot_est = 18'((64'(a_q.hash) * 64'(ModRecip)) >> RecipShift);
  assign rem_raw  = b_q.hash - (32'(b_quot_q) * IdModulus);
  assign rem_fix  = (rem_raw >= IdModulus) ? (rem_raw - IdModulus) : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= push;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
      if (out_en) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && push) begin
      a_q <= push_entry;
    end
    if (b_en && a_valid_q) begin
      b_q      <= a_q;
      b_quot_q <= quot_est;
    end
    if (out_en && b_valid_q) begin
      out_q <= '{token_id: IdW'(rem_fix), attend: b_q.attend, last_token: b_q.last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  // state returns to reset after end of text
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_item_i.kind == KindEnd)) |=> ((count_q == '0) && !inside_q &&
      !held_valid_q && (word_hash_q == FnvBasis)))
    else $error("state not cleared after end of text");

  // token count never passes the hard limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxTokensLimit))
    else $error("token count beyond limit");

  // no input taken while padding or the final token is pending
  a_seq_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pad_left_q != '0) || seq_final_q) |-> !in_ready_o)
    else $error("input accepted during end-of-text sequence");

  // results carry a reduced id, and padding carries id zero
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.token_id < IdW'(30000)) &&
      (out_item_o.attend || (out_item_o.token_id == '0))))
    else $error("token id out of range or nonzero padding");
`endif

endmodule
